@@ rtl/frd_pkg.sv @@
// frd_pkg: shared constants, types and helpers of the frame resync deframer
// depends on nothing; used by every other file of the block but frd_byte_ram
package frd_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int HEADER_BYTES = 4;
    localparam int TAIL_BYTES   = 1;
    localparam int HT_BYTES     = HEADER_BYTES + TAIL_BYTES;

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int LEN_W  = $clog2(HEADER_BYTES + TAIL_BYTES + 65536);

    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 10;
    localparam int STATUS_W   = 3;
    localparam int FRM_LEN_W  = 11;
    localparam int DROPS_W    = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOF_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EOF_BYTE = 1'b1;

    localparam logic [BYTE_W-1:0] SOF_BYTE_RST = 8'd2;
    localparam logic [BYTE_W-1:0] EOF_BYTE_RST = 8'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_WAIT  = 3'd0,
        ST_READY = 3'd1,
        ST_DATA  = 3'd2,
        ST_FULL  = 3'd3,
        ST_NONE  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_CHK,
        S_SCAN_RD1,
        S_SCAN_RD2,
        S_SCAN_LEN,
        S_SCAN_CHK_LEN,
        S_SCAN_END,
        S_EXEC,
        S_READ_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sof_byte;
        logic [BYTE_W-1:0] eof_byte;
    } cfg_t;

    typedef struct packed {
        status_t              status;
        logic [FRM_LEN_W-1:0] frame_length;
        logic [BYTE_W-1:0]    read_data;
        logic [DROPS_W-1:0]   resync_drops;
    } result_t;

    // ring buffer address of base + k, k at most the buffer size
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] k);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(k);
        if (sum >= SUM_W'(BUFFER_BYTES))
        begin
            sum = sum - SUM_W'(BUFFER_BYTES);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

@@ rtl/frd_if.sv @@
// frd_if: valid/ready channel interfaces for commands and results
// depends on frd_pkg
interface frd_in_if;
    logic                          valid;
    logic                          ready;
    logic [frd_pkg::CMD_W-1:0]     command;
    logic [frd_pkg::BYTE_W-1:0]    rx_byte;
    logic [frd_pkg::OFFSET_W-1:0]  read_offset;

    modport source (output valid, output command, output rx_byte, output read_offset,
                    input ready);
    modport sink   (input valid, input command, input rx_byte, input read_offset,
                    output ready);
endinterface

interface frd_out_if;
    logic                          valid;
    logic                          ready;
    logic [frd_pkg::STATUS_W-1:0]  status;
    logic [frd_pkg::FRM_LEN_W-1:0] frame_length;
    logic [frd_pkg::BYTE_W-1:0]    read_data;
    logic [frd_pkg::DROPS_W-1:0]   resync_drops;

    modport source (output valid, output status, output frame_length, output read_data,
                    output resync_drops, input ready);
    modport sink   (input valid, input status, input frame_length, input read_data,
                    input resync_drops, output ready);
endinterface

@@ rtl/frd_byte_ram.sv @@
// frd_byte_ram: generic single-write single-read ram with registered read data
// depends on nothing
module frd_byte_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/frd_cfg_regs.sv @@
// frd_cfg_regs: start and end code registers behind the plain write port
// depends on frd_pkg
module frd_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [frd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [frd_pkg::BYTE_W-1:0]     cfg_wdata,
    output frd_pkg::cfg_t                  cfg
);

    frd_pkg::cfg_t cfg_reg;
    frd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                frd_pkg::CFG_SOF_BYTE: cfg_next.sof_byte = cfg_wdata;
                frd_pkg::CFG_EOF_BYTE: cfg_next.eof_byte = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_byte <= frd_pkg::SOF_BYTE_RST;
            cfg_reg.eof_byte <= frd_pkg::EOF_BYTE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/frd_ctrl.sv @@
// frd_ctrl: sequencer that scans the ring buffer and runs push, read and release
// depends on frd_pkg, frd_if and a byte ram with registered read data
module frd_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    frd_in_if.sink                        in_ch,
    input  frd_pkg::cfg_t                 cfg,
    output logic                          res_valid,
    input  logic                          res_ready,
    output frd_pkg::result_t              res,
    output logic                          ram_we,
    output logic [frd_pkg::ADDR_W-1:0]    ram_waddr,
    output logic [frd_pkg::BYTE_W-1:0]    ram_wdata,
    output logic [frd_pkg::ADDR_W-1:0]    ram_raddr,
    input  logic [frd_pkg::BYTE_W-1:0]    ram_rdata
);

    localparam int LEN_W = frd_pkg::LEN_W;
    localparam int CNT_W = frd_pkg::CNT_W;

    frd_pkg::state_t  state_reg, state_next;
    logic             phase_reg, phase_next;       // 1 during the scan after a command
    logic [frd_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [frd_pkg::BYTE_W-1:0]    rx_reg, rx_next;
    logic [frd_pkg::OFFSET_W-1:0]  off_reg, off_next;
    logic [frd_pkg::ADDR_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic                          pending_reg, pending_next;
    logic [CNT_W-1:0]              plen_reg, plen_next;
    logic [frd_pkg::BYTE_W-1:0]    lo_reg, lo_next;
    logic [LEN_W-1:0]              len_reg, len_next;
    logic [frd_pkg::DROPS_W-1:0]   drops_reg, drops_next;
    frd_pkg::status_t              status_reg, status_next;
    logic [frd_pkg::BYTE_W-1:0]    data_reg, data_next;

    logic             accept;
    logic             short_fill;
    logic             start_ok;
    logic             end_ok;
    logic             too_long;
    logic             need_more;
    logic             has_room;
    logic             off_in;
    logic             scan_exit;
    logic [LEN_W-1:0] len_calc;
    logic [CNT_W-1:0] k_sel;
    frd_pkg::status_t idle_status;

    assign in_ch.ready = (state_reg == frd_pkg::S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    assign short_fill = LEN_W'(fill_reg) < LEN_W'(frd_pkg::HT_BYTES);
    assign start_ok   = ram_rdata == cfg.sof_byte;
    assign end_ok     = ram_rdata == cfg.eof_byte;
    assign len_calc   = LEN_W'(frd_pkg::HEADER_BYTES) + LEN_W'({ram_rdata, lo_reg})
                      + LEN_W'(frd_pkg::TAIL_BYTES);
    assign too_long   = len_reg > LEN_W'(frd_pkg::BUFFER_BYTES);
    assign need_more  = LEN_W'(fill_reg) < len_reg;
    assign has_room   = LEN_W'(fill_reg) < LEN_W'(frd_pkg::BUFFER_BYTES);
    assign off_in     = LEN_W'(off_reg) < LEN_W'(plen_reg);
    assign scan_exit  = ((state_reg == frd_pkg::S_SCAN_CHK) && (pending_reg || short_fill))
                     || ((state_reg == frd_pkg::S_SCAN_CHK_LEN) && !too_long && need_more);
    assign idle_status = pending_reg ? frd_pkg::ST_READY : frd_pkg::ST_WAIT;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = frd_pkg::S_SCAN_CHK;
                end
            end
            frd_pkg::S_SCAN_CHK:
            begin
                if (scan_exit)
                begin
                    state_next = phase_reg ? frd_pkg::S_DONE : frd_pkg::S_EXEC;
                end
                else
                begin
                    state_next = frd_pkg::S_SCAN_RD1;
                end
            end
            frd_pkg::S_SCAN_RD1:
            begin
                state_next = start_ok ? frd_pkg::S_SCAN_RD2 : frd_pkg::S_SCAN_CHK;
            end
            frd_pkg::S_SCAN_RD2:     state_next = frd_pkg::S_SCAN_LEN;
            frd_pkg::S_SCAN_LEN:     state_next = frd_pkg::S_SCAN_CHK_LEN;
            frd_pkg::S_SCAN_CHK_LEN:
            begin
                if (too_long)
                begin
                    state_next = frd_pkg::S_SCAN_CHK;
                end
                else if (need_more)
                begin
                    state_next = phase_reg ? frd_pkg::S_DONE : frd_pkg::S_EXEC;
                end
                else
                begin
                    state_next = frd_pkg::S_SCAN_END;
                end
            end
            frd_pkg::S_SCAN_END:     state_next = frd_pkg::S_SCAN_CHK;
            frd_pkg::S_EXEC:
            begin
                case (cmd_reg)
                    frd_pkg::CMD_PUSH:
                        state_next = has_room ? frd_pkg::S_SCAN_CHK : frd_pkg::S_DONE;
                    frd_pkg::CMD_READ:
                        state_next = (pending_reg && off_in) ? frd_pkg::S_READ_WAIT
                                                             : frd_pkg::S_DONE;
                    frd_pkg::CMD_RELEASE:
                        state_next = pending_reg ? frd_pkg::S_SCAN_CHK : frd_pkg::S_DONE;
                    default:
                        state_next = frd_pkg::S_DONE;
                endcase
            end
            frd_pkg::S_READ_WAIT:    state_next = frd_pkg::S_DONE;
            frd_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = frd_pkg::S_IDLE;
                end
            end
            default:                 state_next = frd_pkg::S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        rx_next      = rx_reg;
        off_next     = off_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        pending_next = pending_reg;
        plen_next    = plen_reg;
        lo_next      = lo_reg;
        len_next     = len_reg;
        drops_next   = drops_reg;
        status_next  = status_reg;
        data_next    = data_reg;
        ram_we       = 1'b0;
        k_sel        = '0;

        // a scan that ends after a command settles the status
        if (scan_exit && phase_reg)
        begin
            status_next = idle_status;
        end

        unique case (state_reg)
            frd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = in_ch.command;
                    rx_next    = in_ch.rx_byte;
                    off_next   = in_ch.read_offset;
                    phase_next = 1'b0;
                    drops_next = '0;
                    data_next  = '0;
                end
            end
            frd_pkg::S_SCAN_CHK:
            begin
                k_sel = '0;
            end
            frd_pkg::S_SCAN_RD1:
            begin
                k_sel = CNT_W'(1);
                if (!start_ok)
                begin
                    head_next  = frd_pkg::wrap_add(head_reg, CNT_W'(1));
                    fill_next  = fill_reg - CNT_W'(1);
                    drops_next = drops_reg + frd_pkg::DROPS_W'(1);
                end
            end
            frd_pkg::S_SCAN_RD2:
            begin
                k_sel   = CNT_W'(2);
                lo_next = ram_rdata;
            end
            frd_pkg::S_SCAN_LEN:
            begin
                len_next = len_calc;
            end
            frd_pkg::S_SCAN_CHK_LEN:
            begin
                k_sel = CNT_W'(len_reg - LEN_W'(1));
                if (too_long)
                begin
                    head_next  = frd_pkg::wrap_add(head_reg, CNT_W'(1));
                    fill_next  = fill_reg - CNT_W'(1);
                    drops_next = drops_reg + frd_pkg::DROPS_W'(1);
                end
            end
            frd_pkg::S_SCAN_END:
            begin
                if (end_ok)
                begin
                    pending_next = 1'b1;
                    plen_next    = CNT_W'(len_reg);
                end
                else
                begin
                    head_next  = frd_pkg::wrap_add(head_reg, CNT_W'(1));
                    fill_next  = fill_reg - CNT_W'(1);
                    drops_next = drops_reg + frd_pkg::DROPS_W'(1);
                end
            end
            frd_pkg::S_EXEC:
            begin
                case (cmd_reg)
                    frd_pkg::CMD_PUSH:
                    begin
                        k_sel = fill_reg;
                        if (has_room)
                        begin
                            ram_we     = 1'b1;
                            fill_next  = fill_reg + CNT_W'(1);
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            status_next = frd_pkg::ST_FULL;
                        end
                    end
                    frd_pkg::CMD_READ:
                    begin
                        k_sel = CNT_W'(off_reg);
                        if (!pending_reg)
                        begin
                            status_next = frd_pkg::ST_NONE;
                        end
                        else if (!off_in)
                        begin
                            status_next = frd_pkg::ST_READY;
                        end
                    end
                    frd_pkg::CMD_RELEASE:
                    begin
                        if (pending_reg)
                        begin
                            head_next    = frd_pkg::wrap_add(head_reg, plen_reg);
                            fill_next    = fill_reg - plen_reg;
                            pending_next = 1'b0;
                            plen_next    = '0;
                            phase_next   = 1'b1;
                        end
                        else
                        begin
                            status_next = frd_pkg::ST_NONE;
                        end
                    end
                    default:
                    begin
                        status_next = idle_status;
                    end
                endcase
            end
            frd_pkg::S_READ_WAIT:
            begin
                data_next   = ram_rdata;
                status_next = frd_pkg::ST_DATA;
            end
            frd_pkg::S_DONE:
            begin
                k_sel = '0;
            end
            default:
            begin
                k_sel = '0;
            end
        endcase
    end

    // one shared ring address adder serves every ram access
    assign ram_raddr = frd_pkg::wrap_add(head_reg, k_sel);
    assign ram_waddr = ram_raddr;
    assign ram_wdata = rx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= frd_pkg::S_IDLE;
            phase_reg   <= 1'b0;
            head_reg    <= '0;
            fill_reg    <= '0;
            pending_reg <= 1'b0;
            plen_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            pending_reg <= pending_next;
            plen_reg    <= plen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        rx_reg     <= rx_next;
        off_reg    <= off_next;
        lo_reg     <= lo_next;
        len_reg    <= len_next;
        drops_reg  <= drops_next;
        status_reg <= status_next;
        data_reg   <= data_next;
    end

    assign res_valid           = (state_reg == frd_pkg::S_DONE);
    assign res.status          = status_reg;
    assign res.frame_length    = pending_reg ? frd_pkg::FRM_LEN_W'(plen_reg) : '0;
    assign res.read_data       = data_reg;
    assign res.resync_drops    = drops_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(fill_reg) <= LEN_W'(frd_pkg::BUFFER_BYTES))
        else $error("fill count above buffer size");

    a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (plen_reg <= fill_reg)
                        && (LEN_W'(plen_reg) >= LEN_W'(frd_pkg::HT_BYTES)))
        else $error("pending frame length not backed by buffered bytes");

    a_no_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg |-> (plen_reg == '0))
        else $error("stale frame length with no frame pending");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == frd_pkg::S_SCAN_CHK))
        else $error("accepted item did not start a scan");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> has_room && (state_reg == frd_pkg::S_EXEC))
        else $error("buffer write without room");
`endif

endmodule

@@ rtl/frame_resync_deframer.sv @@
// frame_resync_deframer: top level of the start/length/end deframer with resync
// depends on frd_pkg, frd_if, frd_byte_ram, frd_cfg_regs and frd_ctrl
//
// Each command transfer (push a received byte, read a byte of the pending
// frame at an offset, or release the pending frame) returns exactly one
// result transfer. Every command first rescans the ring buffer head with the
// current start and end codes, then runs, and a push that stores its byte or
// a release of a pending frame rescans again. The block is busy for the whole
// command: in_ch.ready is high only while it is idle. All buffer accesses go
// through one byte ram with a registered read port and one ring address
// adder. The scan drops the head byte on a wrong start code, an oversize
// length or a wrong end byte, and holds a frame that it finds. A finished
// result sits in an output register, so the next command can be taken while
// it waits. The byte store is not cleared at reset; only buffered bytes are
// ever read. The start and end codes are written through
// cfg_we/cfg_index/cfg_wdata and reset to 2 and 3.
module frame_resync_deframer (
    input  logic                           clk,
    input  logic                           rst_n,
    frd_in_if.sink                         in_ch,
    frd_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [frd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [frd_pkg::BYTE_W-1:0]     cfg_wdata
);

    frd_pkg::cfg_t    cfg;
    frd_pkg::result_t res;
    frd_pkg::result_t out_res_reg, out_res_next;
    logic             out_valid_reg, out_valid_next;
    logic             res_valid;
    logic             res_ready;

    logic                          ram_we;
    logic [frd_pkg::ADDR_W-1:0]    ram_waddr;
    logic [frd_pkg::BYTE_W-1:0]    ram_wdata;
    logic [frd_pkg::ADDR_W-1:0]    ram_raddr;
    logic [frd_pkg::BYTE_W-1:0]    ram_rdata;

    // code registers: the user writes them only while the block is idle; the block itself does not enforce it
    frd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // ring buffer of received bytes
    frd_byte_ram #(
        .DEPTH (frd_pkg::BUFFER_BYTES),
        .WIDTH (frd_pkg::BYTE_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // scan and command sequencer
    frd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_res_reg.status;
    assign out_ch.frame_length = out_res_reg.frame_length;
    assign out_ch.read_data    = out_res_reg.read_data;
    assign out_ch.resync_drops = out_res_reg.resync_drops;

endmodule

@@ tb/sv/frame_resync_deframer_tb.sv @@
// frame_resync_deframer_tb: self-checking testbench of the start/length/end deframer
// depends on frd_pkg, frd_if and frame_resync_deframer; predicts every result
// from its own shadow copy of the ring buffer and the two frame codes
module frame_resync_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import frd_pkg::*;

    // command value with no function, the block ignores it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // mismatch lines printed before going quiet
    localparam int SHOW_LIMIT = 100;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_wdata;

    frd_in_if  cmd_ch ();
    frd_out_if res_ch ();

    frame_resync_deframer uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (cmd_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow of the deframer: ring buffer, head, fill level, held frame
    logic [BYTE_W-1:0] ring_buf [BUFFER_BYTES];
    int unsigned       ring_head;
    int unsigned       ring_fill;
    bit                frame_held;
    int unsigned       held_len;
    logic [BYTE_W-1:0] model_start;
    logic [BYTE_W-1:0] model_end;

    // one predicted report per accepted command, oldest first
    result_t frame_reports [$];

    int fail_count;
    int sent_items;
    bit tx_idle_en;
    bit rx_idle_en;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // hard stop, far beyond the slowest correct run
    initial
    begin
        #10_000_000;
        $display("[frame_resync_deframer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------

    function automatic logic [BYTE_W-1:0] ring_at(input int unsigned k);
        return ring_buf[(ring_head + k) % BUFFER_BYTES];
    endfunction

    function automatic void drop_head(input int unsigned n);
        if (n > ring_fill)
        begin
            n = ring_fill;
        end
        ring_head = (ring_head + n) % BUFFER_BYTES;
        ring_fill -= n;
    endfunction

    // resync from the head until a frame is held or more bytes are needed
    function automatic int unsigned hunt_frame();
        int unsigned drops;
        int unsigned flen;
        bit          need_more;
        drops = 0;
        need_more = 1'b0;
        while (!frame_held && !need_more)
        begin
            if (ring_fill < HT_BYTES)
            begin
                need_more = 1'b1;
            end
            else if (ring_at(0) != model_start)
            begin
                drop_head(1);
                drops++;
            end
            else
            begin
                // little-endian payload length in header bytes 1 and 2
                flen = HEADER_BYTES + {ring_at(2), ring_at(1)} + TAIL_BYTES;
                if (flen > BUFFER_BYTES)
                begin
                    drop_head(1);
                    drops++;
                end
                else if (ring_fill < flen)
                begin
                    need_more = 1'b1;
                end
                else if (ring_at(flen - 1) != model_end)
                begin
                    drop_head(1);
                    drops++;
                end
                else
                begin
                    frame_held = 1'b1;
                    held_len = flen;
                end
            end
        end
        return drops;
    endfunction

    // applies one command to the shadow state and returns the report it gives
    function automatic result_t deframe_step(input logic [CMD_W-1:0]    cmd,
                                             input logic [BYTE_W-1:0]   rx,
                                             input logic [OFFSET_W-1:0] off);
        result_t     rep;
        int unsigned drops;
        // codes written since the last command count from this rescan on
        drops = hunt_frame();
        rep.read_data = '0;
        case (cmd)
            CMD_PUSH:
            begin
                if (ring_fill < BUFFER_BYTES)
                begin
                    ring_buf[(ring_head + ring_fill) % BUFFER_BYTES] = rx;
                    ring_fill++;
                    drops += hunt_frame();
                    rep.status = frame_held ? ST_READY : ST_WAIT;
                end
                else
                begin
                    // full buffer, byte lost even with a frame held
                    rep.status = ST_FULL;
                end
            end
            CMD_READ:
            begin
                if (!frame_held)
                begin
                    rep.status = ST_NONE;
                end
                else if (off < held_len)
                begin
                    rep.read_data = ring_at(off);
                    rep.status = ST_DATA;
                end
                else
                begin
                    // offset past the frame end: no data, frame still there
                    rep.status = ST_READY;
                end
            end
            CMD_RELEASE:
            begin
                if (frame_held)
                begin
                    drop_head(held_len);
                    frame_held = 1'b0;
                    held_len = 0;
                    drops += hunt_frame();
                    rep.status = frame_held ? ST_READY : ST_WAIT;
                end
                else
                begin
                    rep.status = ST_NONE;
                end
            end
            default:
            begin
                rep.status = frame_held ? ST_READY : ST_WAIT;
            end
        endcase
        rep.frame_length = frame_held ? FRM_LEN_W'(held_len) : '0;
        rep.resync_drops = DROPS_W'(drops);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls and in-order comparison
    // ------------------------------------------------------------------

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= SHOW_LIMIT)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (frame_reports.size() == 0)
            begin
                fail_count++;
                if (fail_count <= SHOW_LIMIT)
                begin
                    $display("%0t: result with none expected, expected nothing, actual status %0d",
                             $time, res_ch.status);
                end
            end
            else
            begin
                want = frame_reports.pop_front();
                check_field("status", 16'(want.status), 16'(res_ch.status));
                check_field("frame_length", 16'(want.frame_length), 16'(res_ch.frame_length));
                check_field("read_data", 16'(want.read_data), 16'(res_ch.read_data));
                check_field("resync_drops", 16'(want.resync_drops), 16'(res_ch.resync_drops));
            end
        end
        // receiver stalls about a third of the time unless told not to
        res_ch.ready <= rx_idle_en ? ($urandom_range(0, 99) >= 32) : 1'b1;
    end

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    // one command transfer; valid stays up afterwards so a following call
    // can go back to back; only drain and the idle stalls here lower it
    task automatic send_cmd(input logic [CMD_W-1:0]    cmd,
                            input logic [BYTE_W-1:0]   rx,
                            input logic [OFFSET_W-1:0] off);
        while (tx_idle_en && $urandom_range(0, 99) < 32)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= cmd;
        cmd_ch.rx_byte     <= rx;
        cmd_ch.read_offset <= off;
        do
        begin
            @(posedge clk);
        end
        while (cmd_ch.ready !== 1'b1);
        frame_reports.push_back(deframe_step(cmd, rx, off));
        if (cmd != CMD_UNUSED)
        begin
            sent_items++;
        end
    endtask

    // unused fields carry random values, the block must ignore them
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        send_cmd(CMD_PUSH, b, OFFSET_W'($urandom));
    endtask

    task automatic read_at(input logic [OFFSET_W-1:0] off);
        send_cmd(CMD_READ, BYTE_W'($urandom), off);
    endtask

    task automatic release_frame();
        send_cmd(CMD_RELEASE, BYTE_W'($urandom), OFFSET_W'($urandom));
    endtask

    // waits until every report is in and the block has surely gone idle
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (frame_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    // both code registers, written only while the block is idle
    task automatic set_codes(input logic [BYTE_W-1:0] start_val,
                             input logic [BYTE_W-1:0] end_val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SOF_BYTE;
        cfg_wdata <= start_val;
        @(posedge clk);
        model_start = start_val;
        cfg_index <= CFG_EOF_BYTE;
        cfg_wdata <= end_val;
        @(posedge clk);
        model_end = end_val;
        cfg_we <= 1'b0;
    endtask

    // a full frame with the current codes, optionally with a bad end byte
    task automatic push_frame(input int unsigned payload_len, input bit good_end);
        push_byte(model_start);
        push_byte(payload_len[7:0]);
        push_byte(payload_len[15:8]);
        repeat (HEADER_BYTES - 3) push_byte(BYTE_W'($urandom));
        repeat (payload_len) push_byte(BYTE_W'($urandom));
        repeat (TAIL_BYTES - 1) push_byte(BYTE_W'($urandom));
        push_byte(good_end ? model_end : model_end ^ BYTE_W'($urandom_range(1, 255)));
    endtask

    // mostly short payloads, now and then a long one
    function automatic int unsigned pick_payload();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            return $urandom_range(0, 12);
        end
        else if (r < 98)
        begin
            return $urandom_range(13, 64);
        end
        return $urandom_range(65, 400);
    endfunction

    // inside the held frame, just past it, or anywhere
    function automatic logic [OFFSET_W-1:0] pick_offset();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (frame_held && r < 60)
        begin
            return OFFSET_W'($urandom_range(0, held_len - 1));
        end
        else if (frame_held && r < 80 && held_len < BUFFER_BYTES)
        begin
            return OFFSET_W'($urandom_range(held_len, BUFFER_BYTES - 1));
        end
        return OFFSET_W'($urandom);
    endfunction

    // mostly well-formed frames with reads and a release, the rest broken
    // frames, stray commands and the unused command value
    task automatic random_traffic(input int unsigned n);
        int unsigned goal;
        int unsigned pick;
        goal = sent_items + n;
        while (sent_items < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                repeat ($urandom_range(0, 2)) push_byte(BYTE_W'($urandom));
                push_frame(pick_payload(), 1'b1);
                repeat ($urandom_range(0, 4)) read_at(pick_offset());
                if ($urandom_range(0, 99) < 85)
                begin
                    release_frame();
                end
            end
            else if (pick < 75)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    push_frame(pick_payload(), 1'b0);
                end
                else
                begin
                    // header claiming more than the buffer can hold
                    push_byte(model_start);
                    push_byte(BYTE_W'($urandom));
                    push_byte(BYTE_W'($urandom_range(4, 255)));
                end
            end
            else if (pick < 97)
            begin
                case ($urandom_range(0, 2))
                    0:       push_byte(BYTE_W'($urandom));
                    1:       read_at(pick_offset());
                    default: release_frame();
                endcase
            end
            else
            begin
                send_cmd(CMD_UNUSED, BYTE_W'($urandom), OFFSET_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset codes: empty-buffer commands, a short frame, oversize and bad end
    task automatic test_directed();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        // nothing buffered yet
        read_at(10'd0);
        read_at(10'd1023);
        release_frame();
        send_cmd(CMD_UNUSED, BYTE_W'($urandom), OFFSET_W'($urandom));
        // two junk bytes ahead of a 6 byte frame, resync drops them
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(model_start);
        push_byte(8'h01);
        push_byte(8'h00);
        push_byte(8'h5A);
        push_byte(8'hC3);
        push_byte(model_end);
        // first byte, last byte, just past the end, far past the end
        read_at(10'd0);
        read_at(10'd5);
        read_at(10'd6);
        read_at(10'd1023);
        send_cmd(CMD_UNUSED, BYTE_W'($urandom), OFFSET_W'($urandom));
        // a start code queued behind the held frame, then release
        push_byte(model_start);
        release_frame();
        // two headers in a row whose length is past the buffer size
        push_byte(model_start);
        push_byte(8'hFC);
        push_byte(8'h03);
        push_byte(8'hAA);
        // right length, wrong end byte
        push_byte(model_start);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h77);
        push_byte(8'h55);
    endtask

    // one frame of the largest length fills the buffer, then pushes overflow
    task automatic test_full_buffer();
        // long stretch with no idling on either side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        push_frame(BUFFER_BYTES - HEADER_BYTES - TAIL_BYTES, 1'b1);
        push_byte(BYTE_W'($urandom));
        push_byte(model_start);
        read_at(10'd0);
        read_at(10'd1023);
        read_at(OFFSET_W'($urandom));
        send_cmd(CMD_UNUSED, BYTE_W'($urandom), OFFSET_W'($urandom));
        release_frame();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // lowest and highest code values, both ways round
    task automatic test_extreme_codes();
        set_codes(8'h00, 8'hFF);
        random_traffic(40);
        set_codes(8'hFF, 8'h00);
        random_traffic(40);
    endtask

    // start and end code the same
    task automatic test_equal_codes();
        set_codes(8'h5A, 8'h5A);
        random_traffic(40);
    endtask

    // random codes, sender back to back while the receiver still stalls
    task automatic test_random_codes();
        set_codes(BYTE_W'($urandom), BYTE_W'($urandom));
        tx_idle_en = 1'b0;
        random_traffic(40);
        tx_idle_en = 1'b1;
    endtask

    // back to the reset codes
    task automatic test_default_codes();
        set_codes(SOF_BYTE_RST, EOF_BYTE_RST);
        random_traffic(40);
    endtask

    initial
    begin
        cmd_ch.valid       <= 1'b0;
        cmd_ch.command     <= CMD_PUSH;
        cmd_ch.rx_byte     <= '0;
        cmd_ch.read_offset <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_SOF_BYTE;
        cfg_wdata          <= '0;
        rst_n              <= 1'b0;
        ring_head   = 0;
        ring_fill   = 0;
        frame_held  = 1'b0;
        held_len    = 0;
        model_start = SOF_BYTE_RST;
        model_end   = EOF_BYTE_RST;
        fail_count  = 0;
        sent_items  = 0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_buffer();
        test_extreme_codes();
        test_equal_codes();
        test_random_codes();
        test_default_codes();

        // every report in, then a quiet tail to catch stray transfers
        drain();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[frame_resync_deframer] OK");
        end
        else
        begin
            $display("[frame_resync_deframer] ERROR");
        end
        $finish;
    end

endmodule
